// File: design/acalc_pkg.sv
// Package for the ASCII infix calculator: widths, character codes,
// operator/status codes and the control types shared by the RTL files.
// No dependencies.
`default_nettype none

package acalc_pkg;

  localparam int unsigned MAX_CHARS     = 127;
  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned OPW           = OPERAND_WIDTH;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = $clog2(MAX_CHARS + 1);
  localparam int unsigned STEP_W  = $clog2(OPERAND_WIDTH);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_OP    = 2'd1,
    STAT_DIV_ZERO = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_CALC,
    CTL_OUT
  } ctl_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADD,
    PH_MUL,
    PH_ABS_A,
    PH_ABS_B,
    PH_DIV,
    PH_FIX,
    PH_DONE
  } alu_ph_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    stat_e status;
  } alu_rsp_t;

endpackage

`default_nettype wire

// File: design/acalc_if.sv
// Valid/ready channel interfaces for the calculator's byte input and
// result output. Depends on acalc_pkg.
`default_nettype none

interface acalc_in_if import acalc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface acalc_out_if import acalc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result;
  logic [STAT_W-1:0]       status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

`default_nettype wire

// File: design/acalc_alu.sv
// Shared iterative arithmetic unit: add/sub, shift-add multiply and
// restoring signed divide, all through one adder. Depends on acalc_pkg.
`default_nettype none

module acalc_alu import acalc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  alu_req_t       req_i,
  input  logic [OPW-1:0] a_i,
  input  logic [OPW-1:0] b_i,
  output alu_rsp_t       rsp_o,
  output logic [OPW-1:0] res_o
);

  alu_ph_e             phase_q, phase_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  op_e                 op_q, op_d;
  stat_e               stat_q, stat_d;
  logic                neg_q, neg_d;
  logic [OPW:0]        acc_q, acc_d;
  logic [OPW-1:0]      mc_q, mc_d;
  logic [OPW-1:0]      mp_q, mp_d;

  logic [OPW:0]        add_a, add_b;
  logic                add_sub;
  logic [OPW+1:0]      add_sum;
  logic                add_cout;
  logic                last_step;

  // the one adder; carry out doubles as the a >= b test in divide
  assign add_sum  = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                  + {{(OPW+1){1'b0}}, add_sub};
  assign add_cout = add_sum[OPW+1];
  assign last_step = (cnt_q == STEP_W'(OPW - 1));

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (phase_q)
      PH_ADD: begin
        add_a   = acc_q;
        add_b   = {1'b0, mc_q};
        add_sub = (op_q == OP_SUB);
      end
      PH_MUL: begin
        add_a = acc_q;
        add_b = {1'b0, mc_q};
      end
      PH_ABS_A: begin
        add_b   = acc_q;
        add_sub = 1'b1;
      end
      PH_ABS_B: begin
        add_b   = {1'b0, mc_q};
        add_sub = 1'b1;
      end
      PH_DIV: begin
        add_a   = {acc_q[OPW-1:0], mp_q[OPW-1]};
        add_b   = {1'b0, mc_q};
        add_sub = 1'b1;
      end
      PH_FIX: begin
        add_b   = {1'b0, mp_q};
        add_sub = neg_q;
      end
      default: ;
    endcase
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            OP_ADD, OP_SUB: phase_d = PH_ADD;
            OP_MUL:         phase_d = PH_MUL;
            OP_DIV:         phase_d = (b_i == '0) ? PH_DONE : PH_ABS_A;
            default:        phase_d = PH_DONE;
          endcase
        end
      end
      PH_ADD:   phase_d = PH_DONE;
      PH_MUL:   phase_d = last_step ? PH_DONE : PH_MUL;
      PH_ABS_A: phase_d = PH_ABS_B;
      PH_ABS_B: phase_d = PH_DIV;
      PH_DIV:   phase_d = last_step ? PH_FIX : PH_DIV;
      PH_FIX:   phase_d = PH_DONE;
      PH_DONE:  phase_d = PH_IDLE;
      default:  phase_d = PH_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d  = cnt_q;
    op_d   = op_q;
    stat_d = stat_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          op_d   = req_i.op;
          stat_d = STAT_OK;
          cnt_d  = '0;
          neg_d  = a_i[OPW-1] ^ b_i[OPW-1];
          acc_d  = {1'b0, a_i};
          mc_d   = b_i;
          mp_d   = b_i;
          case (req_i.op)
            OP_ADD, OP_SUB: ;
            OP_MUL: begin
              acc_d = '0;
              mc_d  = a_i;
            end
            OP_DIV: begin
              if (b_i == '0) begin
                stat_d = STAT_DIV_ZERO;
                acc_d  = '0;
              end
            end
            default: begin
              stat_d = STAT_NO_OP;
              acc_d  = '0;
            end
          endcase
        end
      end
      PH_ADD: acc_d = add_sum[OPW:0];
      PH_MUL: begin
        if (mp_q[0]) begin
          acc_d = add_sum[OPW:0];
        end
        mc_d  = mc_q << 1;
        mp_d  = mp_q >> 1;
        cnt_d = cnt_q + STEP_W'(1);
      end
      PH_ABS_A: begin
        if (acc_q[OPW-1]) begin
          acc_d = add_sum[OPW:0];
        end
      end
      PH_ABS_B: begin
        if (mc_q[OPW-1]) begin
          mc_d = add_sum[OPW-1:0];
        end
        mp_d  = acc_q[OPW-1:0];
        acc_d = '0;
      end
      PH_DIV: begin
        acc_d = add_cout ? add_sum[OPW:0] : add_a;
        mp_d  = {mp_q[OPW-2:0], add_cout};
        cnt_d = cnt_q + STEP_W'(1);
      end
      PH_FIX: acc_d = add_sum[OPW:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    stat_q <= stat_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
    mc_q   <= mc_d;
    mp_q   <= mp_d;
  end

  assign res_o        = acc_q[OPW-1:0];
  assign rsp_o.done   = (phase_q == PH_DONE);
  assign rsp_o.status = stat_q;

endmodule

`default_nettype wire

// File: design/ascii_infix_calculator.sv
// ASCII infix calculator, top level. Depends on acalc_pkg, acalc_if, acalc_alu.
// Input ready is high whenever the control is idle, so ordinary bytes are
// taken back to back. The byte marked last starts the shared ALU for
// add/sub, multiply or divide (one adder pass per bit), then the result is
// held until taken. Input ready stays low from the last byte until then.
// Async active-low reset clears the operands, operator, counters and control.
`default_nettype none

module ascii_infix_calculator import acalc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  acalc_in_if.sink     in_i,
  acalc_out_if.source  out_o
);

  ctl_e             ctl_q, ctl_d;
  logic [OPW-1:0]   first_q, first_d, first_n;
  logic [OPW-1:0]   second_q, second_d, second_n;
  op_e              op_q, op_d, op_n;
  logic             after_q, after_d, after_n;
  logic             term_q, term_d, term_n;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic [RES_W-1:0] result_q, result_d;
  stat_e            status_q, status_d;

  logic             in_fire;
  logic             live;
  logic [CHAR_W-1:0] digit;
  logic [OPW-1:0]   acc_src, acc_new;
  logic [OPW+RES_W-1:0] res_ext;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [OPW-1:0]   alu_res;

  assign in_i.ready = (ctl_q == CTL_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign live       = !term_q && (cnt_q < CNT_W'(MAX_CHARS));

  // value*10 + digit as two shifts and two adds
  assign digit   = in_i.character - CH_ZERO;
  assign acc_src = after_q ? second_q : first_q;
  assign acc_new = (acc_src << 3) + (acc_src << 1)
                 + {{(OPW-4){1'b0}}, digit[3:0]};

  // state after this byte has been taken into account
  always_comb begin
    first_n  = first_q;
    second_n = second_q;
    op_n     = op_q;
    after_n  = after_q;
    term_n   = term_q;
    cnt_n    = cnt_q;
    if (live) begin
      cnt_n = cnt_q + CNT_W'(1);
      if (in_i.character == CH_NUL) begin
        term_n = 1'b1;
      end else if (in_i.character inside {[CH_ZERO:CH_NINE]}) begin
        if (after_q) begin
          second_n = acc_new;
        end else begin
          first_n = acc_new;
        end
      end else begin
        case (in_i.character)
          CH_PLUS: begin
            op_n    = OP_ADD;
            after_n = 1'b1;
          end
          CH_MINUS: begin
            op_n    = OP_SUB;
            after_n = 1'b1;
          end
          CH_STAR: begin
            op_n    = OP_MUL;
            after_n = 1'b1;
          end
          CH_SLASH: begin
            op_n    = OP_DIV;
            after_n = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    op_d     = op_q;
    after_d  = after_q;
    term_d   = term_q;
    cnt_d    = cnt_q;
    if (in_fire) begin
      if (in_i.last) begin
        first_d  = '0;
        second_d = '0;
        op_d     = OP_NONE;
        after_d  = 1'b0;
        term_d   = 1'b0;
        cnt_d    = '0;
      end else begin
        first_d  = first_n;
        second_d = second_n;
        op_d     = op_n;
        after_d  = after_n;
        term_d   = term_n;
        cnt_d    = cnt_n;
      end
    end
  end

  assign alu_req.start = in_fire && in_i.last;
  assign alu_req.op    = op_n;

  acalc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (first_n),
    .b_i    (second_n),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  // sign-extend from operand width, then keep the low 32 bits
  assign res_ext  = {{RES_W{alu_res[OPW-1]}}, alu_res};
  assign result_d = alu_rsp.done ? res_ext[RES_W-1:0] : result_q;
  assign status_d = alu_rsp.done ? alu_rsp.status : status_q;

  // next state
  always_comb begin
    ctl_d = ctl_q;
    case (ctl_q)
      CTL_IDLE: if (in_fire && in_i.last) ctl_d = CTL_CALC;
      CTL_CALC: if (alu_rsp.done) ctl_d = CTL_OUT;
      CTL_OUT:  if (out_o.ready) ctl_d = CTL_IDLE;
      default:  ctl_d = CTL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_o.valid  = (ctl_q == CTL_OUT);
    out_o.result = result_q;
    out_o.status = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= CTL_IDLE;
      first_q  <= '0;
      second_q <= '0;
      op_q     <= OP_NONE;
      after_q  <= 1'b0;
      term_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      ctl_q    <= ctl_d;
      first_q  <= first_d;
      second_q <= second_d;
      op_q     <= op_d;
      after_q  <= after_d;
      term_q   <= term_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    status_q <= status_d;
  end

endmodule

`default_nettype wire
